// ===== rtl/sfr_pkg.sv =====
package sfr_pkg;

    // One item on the input side.
    typedef struct packed {
        logic       op;
        logic [7:0] rx_byte;
    } t_in_item;

    // One result item.
    typedef struct packed {
        logic [2:0]  event_res;
        logic [7:0]  payload_byte;
        logic [15:0] payload_index;
        logic [7:0]  frame_command;
        logic [7:0]  frame_version;
        logic [15:0] frame_length;
    } t_out_item;

    // An input item after classification by the front part.
    typedef struct packed {
        logic       is_tick;
        logic       sync_first;
        logic       sync_second;
        logic [7:0] rx_byte;
    } t_front_item;

    typedef enum logic [2:0] {
        EV_NONE    = 3'd0,
        EV_HEADER  = 3'd1,
        EV_PAYLOAD = 3'd2,
        EV_GOOD    = 3'd3,
        EV_BADSUM  = 3'd4,
        EV_REJECT  = 3'd5,
        EV_TIMEOUT = 3'd6
    } t_event;

    localparam logic       OP_BYTE     = 1'b0;
    localparam logic       OP_TICK     = 1'b1;
    localparam logic [7:0] SYNC_FIRST  = 8'h55;
    localparam logic [7:0] SYNC_SECOND = 8'hAA;

    localparam int          POS_WIDTH     = 17;
    localparam logic [16:0] POS_SYNC1     = 17'd0;
    localparam logic [16:0] POS_SYNC2     = 17'd1;
    localparam logic [16:0] POS_VERSION   = 17'd2;
    localparam logic [16:0] POS_COMMAND   = 17'd3;
    localparam logic [16:0] POS_LEN_HI    = 17'd4;
    localparam logic [16:0] POS_LEN_LO    = 17'd5;
    localparam logic [16:0] HEADER_BYTES  = 17'd6;

    localparam logic [15:0] TIMEOUT_RESET = 16'd300;

endpackage

// ===== rtl/sfr_fifo.sv =====
module sfr_fifo import sfr_pkg::*; #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr,
    input  logic [WIDTH-1:0] i_wdata,
    output logic             o_full,
    input  logic             i_rd,
    output logic [WIDTH-1:0] o_rdata,
    output logic             o_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]    r_count, n_count;
    logic             wr_en, rd_en;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_rdata = r_mem[r_rd_ptr];
    assign wr_en   = i_wr && !o_full;
    assign rd_en   = i_rd && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (wr_en) begin
            n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
        end
        if (rd_en) begin
            n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
        end
        if (wr_en && !rd_en) begin
            n_count = r_count + CW'(1);
        end else if (rd_en && !wr_en) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= i_wdata;
        end
    end

endmodule

// ===== rtl/sfr_front.sv =====
module sfr_front import sfr_pkg::*; #(
    parameter int DEPTH = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    input  t_in_item    i_item,
    output logic        o_full,
    input  logic        i_take,
    output t_front_item o_item,
    output logic        o_valid
);

    t_front_item cls_item;
    logic        q_empty;

    // Sync bytes are compared here so that the parser sees single flags.
    always_comb begin
        cls_item.is_tick     = (i_item.op == OP_TICK);
        cls_item.sync_first  = (i_item.rx_byte == SYNC_FIRST);
        cls_item.sync_second = (i_item.rx_byte == SYNC_SECOND);
        cls_item.rx_byte     = i_item.rx_byte;
    end

    sfr_fifo #(
        .WIDTH ($bits(t_front_item)),
        .DEPTH (DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (i_push),
        .i_wdata (cls_item),
        .o_full  (o_full),
        .i_rd    (i_take),
        .o_rdata (o_item),
        .o_empty (q_empty)
    );

    assign o_valid = !q_empty;

endmodule

// ===== rtl/sfr_back.sv =====
module sfr_back import sfr_pkg::*; #(
    parameter int DEPTH = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [15:0] i_timeout,
    input  logic        i_valid,
    input  t_front_item i_item,
    output logic        o_take,
    input  logic        i_pop,
    output t_out_item   o_item,
    output logic        o_empty
);

    logic [POS_WIDTH-1:0] r_position, n_position;
    logic [7:0]           r_version, n_version;
    logic [7:0]           r_command, n_command;
    logic [15:0]          r_length, n_length;
    logic [7:0]           r_sum, n_sum;
    logic [15:0]          r_idle, n_idle;

    logic [POS_WIDTH-1:0] offset;
    logic [15:0]          idle_inc;
    logic                 out_full;
    t_event               ev;
    t_out_item            res;

    assign o_take   = i_valid && !out_full;
    assign offset   = r_position - HEADER_BYTES;
    assign idle_inc = (r_idle != '1) ? r_idle + 16'd1 : r_idle;

    always_comb begin
        n_position = r_position;
        n_version  = r_version;
        n_command  = r_command;
        n_length   = r_length;
        n_sum      = r_sum;
        n_idle     = r_idle;
        ev         = EV_NONE;
        res.payload_byte  = '0;
        res.payload_index = '0;

        if (i_item.is_tick) begin
            n_idle = idle_inc;
            if (r_position != POS_SYNC1 && idle_inc > i_timeout) begin
                n_position = POS_SYNC1;
                ev         = EV_TIMEOUT;
            end
        end else begin
            case (r_position)
                POS_SYNC1: begin
                    if (i_item.sync_first) begin
                        n_version = '0;
                        n_command = '0;
                        n_length  = '0;
                        ev        = EV_HEADER;
                    end else begin
                        ev = EV_REJECT;
                    end
                end
                POS_SYNC2: begin
                    if (i_item.sync_second) begin
                        ev = EV_HEADER;
                    end else begin
                        n_position = POS_SYNC1;
                        ev         = EV_REJECT;
                    end
                end
                POS_VERSION: begin
                    n_version = i_item.rx_byte;
                    ev        = EV_HEADER;
                end
                POS_COMMAND: begin
                    n_command = i_item.rx_byte;
                    ev        = EV_HEADER;
                end
                POS_LEN_HI: begin
                    n_length = {i_item.rx_byte, 8'h00};
                    ev       = EV_HEADER;
                end
                POS_LEN_LO: begin
                    n_length = {r_length[15:8], i_item.rx_byte};
                    ev       = EV_HEADER;
                end
                default: begin
                    if (offset < {1'b0, r_length}) begin
                        res.payload_byte  = i_item.rx_byte;
                        res.payload_index = offset[15:0];
                        ev                = EV_PAYLOAD;
                    end else begin
                        // The byte after the payload is the checksum.
                        n_position = POS_SYNC1;
                        n_idle     = '0;
                        ev         = (i_item.rx_byte == r_sum) ? EV_GOOD : EV_BADSUM;
                    end
                end
            endcase

            if (ev == EV_HEADER || ev == EV_PAYLOAD) begin
                // A new frame restarts the sum at its first byte.
                n_sum      = (r_position == POS_SYNC1) ? i_item.rx_byte
                                                        : r_sum + i_item.rx_byte;
                n_position = r_position + POS_WIDTH'(1);
                n_idle     = '0;
            end
        end

        res.event_res     = ev;
        res.frame_command = n_command;
        res.frame_version = n_version;
        res.frame_length  = n_length;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_position <= '0;
            r_version  <= '0;
            r_command  <= '0;
            r_length   <= '0;
            r_sum      <= '0;
            r_idle     <= '0;
        end else if (o_take) begin
            r_position <= n_position;
            r_version  <= n_version;
            r_command  <= n_command;
            r_length   <= n_length;
            r_sum      <= n_sum;
            r_idle     <= n_idle;
        end
    end

    sfr_fifo #(
        .WIDTH ($bits(t_out_item)),
        .DEPTH (DEPTH)
    ) u_result_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (o_take),
        .i_wdata (res),
        .o_full  (out_full),
        .i_rd    (i_pop),
        .o_rdata (o_item),
        .o_empty (o_empty)
    );

endmodule

// ===== rtl/serial_frame_receiver.sv =====
// Channel   | Handshake                 | Payload
// ----------+---------------------------+---------------------------
// input     | push / full               | i_in_item  (t_in_item)
// result    | empty / pop               | o_out_item (t_out_item)
// config    | i_cfg_valid / o_cfg_ready | i_cfg_data (timeout_ms)
//
// Every input item gives exactly one result item; one item per cycle is
// sustained while the result queue is not full, with the parser between two queues.
// An accepted item is held in the input queue, taken by the parser and written into the result queue.
// After reset both queues are empty, timeout_ms is 300 and the parser
// waits for the first sync byte. A stalled result side fills the result
// queue and then the input queue before full rises.
module serial_frame_receiver import sfr_pkg::*; #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    input  t_in_item    i_in_item,
    output logic        full,
    input  logic        pop,
    output t_out_item   o_out_item,
    output logic        empty,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data
);

    logic [15:0] r_timeout;
    t_front_item front_item;
    logic        front_valid;
    logic        front_take;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= TIMEOUT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_timeout <= i_cfg_data;
        end
    end

    sfr_front #(
        .DEPTH (QUEUE_DEPTH)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (i_in_item),
        .o_full  (full),
        .i_take  (front_take),
        .o_item  (front_item),
        .o_valid (front_valid)
    );

    sfr_back #(
        .DEPTH (QUEUE_DEPTH)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_timeout (r_timeout),
        .i_valid   (front_valid),
        .i_item    (front_item),
        .o_take    (front_take),
        .i_pop     (pop),
        .o_item    (o_out_item),
        .o_empty   (empty)
    );

    a_reset_queues: assert property (@(posedge i_clk)
        !i_rst_n |=> empty && !full)
        else $error("queues not empty after reset");

    a_payload_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && o_out_item.event_res == EV_PAYLOAD |->
            {1'b0, o_out_item.payload_index} < {1'b0, o_out_item.frame_length})
        else $error("payload index beyond frame length");

    a_no_payload_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && o_out_item.event_res != EV_PAYLOAD |->
            o_out_item.payload_byte == '0 && o_out_item.payload_index == '0)
        else $error("payload fields set on a non-payload result");

endmodule

// ===== dv/tb_serial_frame_receiver.sv =====
`timescale 1ns / 100ps

module tb_serial_frame_receiver;
    import sfr_pkg::*;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        push        = 1'b0;
    t_in_item    i_in_item   = '0;
    logic        pop         = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic [15:0] i_cfg_data  = '0;
    logic        full;
    logic        empty;
    logic        o_cfg_ready;
    t_out_item   o_out_item;

    serial_frame_receiver dut (
        .i_clk,
        .i_rst_n,
        .push,
        .i_in_item,
        .full,
        .pop,
        .o_out_item,
        .empty,
        .i_cfg_valid,
        .o_cfg_ready,
        .i_cfg_data
    );

    t_in_item    rx_items_pending[$];
    t_out_item   parser_results_due[$];
    logic [15:0] timeout_writes[$];
    t_out_item   due_item;
    int          mismatch_count = 0;
    bit          steady_flow    = 1'b0;
    int          phase_timeout  = TIMEOUT_RESET;

    // Predicted parser state.
    logic [16:0] prs_pos     = '0;
    logic [7:0]  prs_version = '0;
    logic [7:0]  prs_command = '0;
    logic [15:0] prs_length  = '0;
    logic [7:0]  prs_sum     = '0;
    logic [15:0] prs_idle    = '0;
    logic [15:0] prs_timeout = TIMEOUT_RESET;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    initial begin
        #20_000_000;
        $display("** serial_frame_receiver: FAILED **");
        $finish;
    end

    function automatic void take_byte(input logic [7:0] b);
        prs_sum  = prs_sum + b;
        prs_pos  = prs_pos + 17'd1;
        prs_idle = '0;
    endfunction

    function automatic t_out_item frame_parse(input t_in_item it);
        t_out_item   r;
        logic [16:0] off;
        r = '0;
        if (it.op == OP_TICK) begin
            if (prs_idle != 16'hFFFF) begin
                prs_idle = prs_idle + 16'd1;
            end
            if (prs_pos != POS_SYNC1 && prs_idle > prs_timeout) begin
                prs_pos     = POS_SYNC1;
                r.event_res = EV_TIMEOUT;
            end else begin
                r.event_res = EV_NONE;
            end
        end else begin
            case (prs_pos)
                POS_SYNC1: begin
                    if (it.rx_byte != SYNC_FIRST) begin
                        r.event_res = EV_REJECT;
                    end else begin
                        prs_sum     = '0;
                        prs_version = '0;
                        prs_command = '0;
                        prs_length  = '0;
                        take_byte(it.rx_byte);
                        r.event_res = EV_HEADER;
                    end
                end
                POS_SYNC2: begin
                    // A wrong second sync byte is dropped, not retried as a first one.
                    if (it.rx_byte != SYNC_SECOND) begin
                        prs_pos     = POS_SYNC1;
                        r.event_res = EV_REJECT;
                    end else begin
                        take_byte(it.rx_byte);
                        r.event_res = EV_HEADER;
                    end
                end
                POS_VERSION: begin
                    prs_version = it.rx_byte;
                    take_byte(it.rx_byte);
                    r.event_res = EV_HEADER;
                end
                POS_COMMAND: begin
                    prs_command = it.rx_byte;
                    take_byte(it.rx_byte);
                    r.event_res = EV_HEADER;
                end
                POS_LEN_HI: begin
                    prs_length = {it.rx_byte, 8'h00};
                    take_byte(it.rx_byte);
                    r.event_res = EV_HEADER;
                end
                POS_LEN_LO: begin
                    prs_length[7:0] = it.rx_byte;
                    take_byte(it.rx_byte);
                    r.event_res = EV_HEADER;
                end
                default: begin
                    off = prs_pos - HEADER_BYTES;
                    if (off < {1'b0, prs_length}) begin
                        r.event_res     = EV_PAYLOAD;
                        r.payload_byte  = it.rx_byte;
                        r.payload_index = off[15:0];
                        take_byte(it.rx_byte);
                    end else begin
                        r.event_res = (it.rx_byte == prs_sum) ? EV_GOOD : EV_BADSUM;
                        prs_pos     = POS_SYNC1;
                        prs_idle    = '0;
                    end
                end
            endcase
        end
        r.frame_command = prs_command;
        r.frame_version = prs_version;
        r.frame_length  = prs_length;
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
        if (want !== got) begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatch_count++;
        end
    endfunction

    // Input side and the timeout register write channel.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            push        <= 1'b0;
            i_cfg_valid <= 1'b0;
        end else begin
            if (push && !full) begin
                parser_results_due = {parser_results_due, frame_parse(i_in_item)};
                void'(rx_items_pending.pop_front());
            end
            if (i_cfg_valid && o_cfg_ready) begin
                prs_timeout = i_cfg_data;
                void'(timeout_writes.pop_front());
            end
            if (!(push && full)) begin
                if (rx_items_pending.size() != 0 &&
                    (steady_flow || $urandom_range(99) >= 33)) begin
                    push      <= 1'b1;
                    i_in_item <= rx_items_pending[0];
                end else begin
                    push <= 1'b0;
                end
            end
            if (!(i_cfg_valid && !o_cfg_ready)) begin
                if (timeout_writes.size() != 0) begin
                    i_cfg_valid <= 1'b1;
                    i_cfg_data  <= timeout_writes[0];
                end else begin
                    i_cfg_valid <= 1'b0;
                end
            end
        end
    end

    // Result side.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                if (parser_results_due.size() == 0) begin
                    $display("%0t ns: result with no item pending, actual event %0d",
                             $time, o_out_item.event_res);
                    mismatch_count++;
                end else begin
                    due_item = parser_results_due.pop_front();
                    check_field("event_res", 16'(due_item.event_res),
                                16'(o_out_item.event_res));
                    check_field("payload_byte", 16'(due_item.payload_byte),
                                16'(o_out_item.payload_byte));
                    check_field("payload_index", due_item.payload_index,
                                o_out_item.payload_index);
                    check_field("frame_command", 16'(due_item.frame_command),
                                16'(o_out_item.frame_command));
                    check_field("frame_version", 16'(due_item.frame_version),
                                16'(o_out_item.frame_version));
                    check_field("frame_length", due_item.frame_length, o_out_item.frame_length);
                end
            end
            pop <= steady_flow || $urandom_range(99) >= 33;
        end
    end

    task automatic add_byte(input logic [7:0] b);
        t_in_item it;
        it.op      = OP_BYTE;
        it.rx_byte = b;
        rx_items_pending = {rx_items_pending, it};
    endtask

    task automatic add_ticks(input int n);
        t_in_item it;
        repeat (n) begin
            it.op      = OP_TICK;
            it.rx_byte = 8'($urandom);
            rx_items_pending = {rx_items_pending, it};
        end
    endtask

    // Ticks between two bytes of a frame; never enough to time the frame out.
    function automatic int gap_ticks();
        int cap;
        int pick;
        cap  = (phase_timeout <= 64) ? phase_timeout : 3;
        pick = $urandom_range(99);
        if (cap == 0 || pick < 70) begin
            return 0;
        end else if (pick < 92) begin
            return $urandom_range(1, (cap < 3) ? cap : 3);
        end
        return cap;
    endfunction

    // Sends the first stop_after bytes of a frame. A frame cut short is left to time out.
    task automatic add_frame(input logic [7:0] ver, input logic [7:0] cmd,
                             input logic [15:0] len, input int stop_after, input bit good,
                             input int pause);
        logic [7:0] hdr [6];
        logic [7:0] sum;
        logic [7:0] b;
        int         total;
        hdr   = '{SYNC_FIRST, SYNC_SECOND, ver, cmd, len[15:8], len[7:0]};
        total = 6 + len;
        sum   = '0;
        for (int k = 0; k < total && k < stop_after; k++) begin
            b = (k < 6) ? hdr[k] : 8'($urandom);
            if (k > 0) begin
                add_ticks(gap_ticks());
            end
            if (k == 6) begin
                add_ticks(pause);
            end
            add_byte(b);
            sum = sum + b;
        end
        if (stop_after < total) begin
            add_ticks(phase_timeout + 1 + $urandom_range(2));
        end else begin
            add_ticks(gap_ticks());
            add_byte(good ? sum : sum ^ 8'($urandom_range(1, 255)));
        end
    endtask

    task automatic add_traffic(input int n);
        int          start;
        int          pick;
        int          k;
        logic [7:0]  b;
        logic [7:0]  prev;
        logic [15:0] len;
        start = rx_items_pending.size();
        while (rx_items_pending.size() - start < n) begin
            pick = $urandom_range(99);
            if (pick >= 60 && pick < 72 && phase_timeout <= 64) begin
                len = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(1, 8));
                add_frame(8'($urandom), 8'($urandom), len,
                          $urandom_range(1, 5 + ((len < 4) ? len : 4)), 1'b1, 0);
            end else if (pick < 72) begin
                len = ($urandom_range(9) == 0) ? 16'($urandom_range(9, 40))
                                               : 16'($urandom_range(8));
                add_frame(8'($urandom), 8'($urandom), len, 6 + len,
                          $urandom_range(3) != 0, 0);
            end else if (pick < 84) begin
                // Line noise rich in sync bytes, kept from forming a full sync pair.
                prev = 8'h00;
                repeat ($urandom_range(1, 6)) begin
                    k = $urandom_range(99);
                    if (k < 10) begin
                        add_ticks(1);
                    end else begin
                        if (k < 35) begin
                            b = SYNC_FIRST;
                        end else if (k < 50) begin
                            b = SYNC_SECOND;
                        end else begin
                            b = 8'($urandom);
                        end
                        if (prev == SYNC_FIRST && b == SYNC_SECOND) begin
                            b = 8'h00;
                        end
                        add_byte(b);
                        prev = b;
                    end
                end
                add_byte(8'h00);
            end else if (pick < 94) begin
                add_byte(SYNC_FIRST);
                if ($urandom_range(2) == 0) begin
                    b = SYNC_FIRST;
                end else begin
                    do b = 8'($urandom); while (b == SYNC_SECOND);
                end
                add_byte(b);
            end else begin
                add_ticks($urandom_range(1, 4));
            end
        end
    endtask

    task automatic wait_drained();
        do @(negedge i_clk);
        while (rx_items_pending.size() != 0 || parser_results_due.size() != 0);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_timeout(input logic [15:0] value);
        phase_timeout = value;
        timeout_writes = {timeout_writes, value};
        do @(negedge i_clk);
        while (timeout_writes.size() != 0);
    endtask

    initial begin
        // Reset timeout: idle tick, both header rejects, a repeated first sync byte.
        add_ticks(1);
        add_byte(8'h00);
        add_byte(SYNC_FIRST);
        add_byte(8'h00);
        add_byte(SYNC_FIRST);
        add_byte(SYNC_FIRST);
        add_frame(8'h00, 8'h00, 16'h0000, 6, 1'b1, 0);
        add_frame(8'hFF, 8'hFF, 16'h0002, 8, 1'b0, 0);
        add_frame(8'h12, 8'h34, 16'hFFFF, 1, 1'b1, 0);
        add_traffic(50);
        wait_drained();

        write_timeout(16'd1);
        add_byte(SYNC_FIRST);
        add_byte(SYNC_SECOND);
        add_ticks(2);
        add_traffic(250);
        wait_drained();

        // Out of the usual range: the first tick discards a partial frame.
        write_timeout(16'd0);
        add_byte(SYNC_FIRST);
        add_ticks(1);
        add_traffic(100);
        wait_drained();

        write_timeout(16'($urandom_range(2, 16)));
        add_traffic(300);
        wait_drained();

        // Largest timeout, with both sides running without idling.
        steady_flow = 1'b1;
        write_timeout(16'hFFFF);
        add_traffic(100);
        wait_drained();
        steady_flow = 1'b0;

        write_timeout(16'($urandom_range(17, 64)));
        add_traffic(150);
        wait_drained();
        repeat (8) @(negedge i_clk);

        if (mismatch_count == 0) begin
            $display("** serial_frame_receiver: PASSED **");
        end else begin
            $display("** serial_frame_receiver: FAILED **");
        end
        $finish;
    end

endmodule
